FILE: hw/rtl/stp_bpdu_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// stp_bpdu_field_extractor_macros.svh
// Assertion macros used by the checker file of the BPDU field extractor.
// ----------------------------------------------------------------------------
`ifndef STP_BPDU_FIELD_EXTRACTOR_MACROS_SVH
`define STP_BPDU_FIELD_EXTRACTOR_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SBFE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbfe assertion failed");

// A stalled signal group holds until taken.
`define SBFE_ASSERT_HOLD(label, ante, sig) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> $stable(sig)) \
		else $error("sbfe stall hold violated");

`endif

FILE: hw/rtl/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg
// Types and constants of the spanning tree BPDU field extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbfe_pkg;

	localparam int CAP_DEPTH    = 36;
	localparam int MIN_BPDU     = 4;
	localparam int MIN_CONF     = 35;
	localparam int LEN_BITS_DEF = 16;
	localparam int PKT_W        = 32;
	localparam int BYTES_W      = 48;
	localparam int VALUE_W      = 64;
	localparam int Q_DEPTH      = 2;

	localparam logic [7:0] TYPE_CONF  = 8'h00;
	localparam logic [7:0] TYPE_RAPID = 8'h02;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_PROTO = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		TAG_PROTO     = 4'd0,
		TAG_VERSION   = 4'd1,
		TAG_TYPE      = 4'd2,
		TAG_FLAGS     = 4'd3,
		TAG_ROOT      = 4'd4,
		TAG_COST      = 4'd5,
		TAG_BRIDGE    = 4'd6,
		TAG_PORT      = 4'd7,
		TAG_MSG_AGE   = 4'd8,
		TAG_MAX_AGE   = 4'd9,
		TAG_HELLO     = 4'd10,
		TAG_FWD_DELAY = 4'd11,
		TAG_V1LEN     = 4'd12,
		TAG_NONE      = 4'd13
	} tag_t;

	// One classified frame, as handed from front to back.
	typedef struct packed {
		logic [CAP_DEPTH-1:0][7:0] cap;
		status_t                   status;
		tag_t                      last_tag;
		logic [PKT_W-1:0]          pkts;
		logic [BYTES_W-1:0]        nbytes;
	} frame_t;

endpackage

FILE: hw/rtl/sbfe_byte_if.sv
// ----------------------------------------------------------------------------
// sbfe_byte_if
// Byte channel carrying BPDU bytes in wire order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/sbfe_rec_if.sv
// ----------------------------------------------------------------------------
// sbfe_rec_if
// Record channel carrying tagged BPDU fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbfe_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  field_tag;
	logic [63:0] field_value;
	logic [31:0] packet_count;
	logic [47:0] byte_count;
	logic        last_record;

	modport source (output valid, output status, output field_tag, output field_value,
		output packet_count, output byte_count, output last_record, input ready);
	modport sink (input valid, input status, input field_tag, input field_value,
		input packet_count, input byte_count, input last_record, output ready);
endinterface

FILE: hw/rtl/sbfe_front.sv
// ----------------------------------------------------------------------------
// sbfe_front
// Captures BPDU bytes, classifies the frame at its last byte and keeps the
// good packet and byte counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfe_front #(
	parameter int LEN_BITS = sbfe_pkg::LEN_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sbfe_byte_if.sink       bytes,
	output logic            push_valid,
	input  logic            push_ready,
	output sbfe_pkg::frame_t push_data
);
	import sbfe_pkg::*;

	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	logic [CAP_DEPTH-1:0][7:0] cap_q;
	logic [CAP_DEPTH-1:0][7:0] cap_next;
	logic [LEN_BITS-1:0]       pos_q;
	logic [LEN_BITS-1:0]       len;
	logic [PKT_W-1:0]          pkts_q;
	logic [PKT_W-1:0]          pkts_next;
	logic [BYTES_W-1:0]        nbytes_q;
	logic [BYTES_W:0]          nbytes_sum;
	logic [BYTES_W-1:0]        nbytes_next;
	logic                      xfer;
	logic                      good;
	logic                      long_fmt;
	logic [7:0]                bpdu_type;

	assign bytes.ready = push_ready;
	assign xfer        = bytes.valid && bytes.ready;

	always_comb begin
		for (int i = 0; i < CAP_DEPTH; i++) begin
			cap_next[i] = (pos_q == LEN_BITS'(i)) ? bytes.data_byte : cap_q[i];
		end
	end

	assign len       = (pos_q != LEN_MAX) ? pos_q + 1'b1 : LEN_MAX;
	assign bpdu_type = cap_next[3];
	assign long_fmt  = (len >= LEN_BITS'(MIN_CONF)) &&
		((bpdu_type == TYPE_CONF) || (bpdu_type == TYPE_RAPID));

	assign nbytes_sum  = {1'b0, nbytes_q} + (BYTES_W + 1)'(len);
	assign nbytes_next = nbytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : nbytes_sum[BYTES_W-1:0];
	assign pkts_next   = (pkts_q != {PKT_W{1'b1}}) ? pkts_q + 1'b1 : pkts_q;

	always_comb begin
		push_data     = '0;
		push_data.cap = cap_next;
		good          = 1'b0;
		if (len < LEN_BITS'(MIN_BPDU)) begin
			push_data.status   = ST_SHORT;
			push_data.last_tag = TAG_NONE;
		end else if ({cap_next[0], cap_next[1]} != 16'h0) begin
			push_data.status   = ST_PROTO;
			push_data.last_tag = TAG_PROTO;
		end else begin
			good               = 1'b1;
			push_data.status   = ST_OK;
			if (!long_fmt) begin
				push_data.last_tag = TAG_TYPE;
			end else if ((len > LEN_BITS'(MIN_CONF)) && (bpdu_type == TYPE_RAPID)) begin
				push_data.last_tag = TAG_V1LEN;
			end else begin
				push_data.last_tag = TAG_FWD_DELAY;
			end
		end
		push_data.pkts   = good ? pkts_next : pkts_q;
		push_data.nbytes = good ? nbytes_next : nbytes_q;
	end

	assign push_valid = xfer && bytes.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pkts_q   <= '0;
			nbytes_q <= '0;
		end else if (xfer) begin
			if (bytes.last_byte) begin
				pos_q <= '0;
				if (good) begin
					pkts_q   <= pkts_next;
					nbytes_q <= nbytes_next;
				end
			end else begin
				pos_q <= len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			cap_q <= cap_next;
		end
	end

endmodule

FILE: hw/rtl/sbfe_queue.sv
// ----------------------------------------------------------------------------
// sbfe_queue
// Short frame queue between the classifier and the record generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sbfe_pkg::frame_t push_data,
	output logic             pop_valid,
	input  logic             pop,
	output sbfe_pkg::frame_t pop_data
);
	import sbfe_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);

	frame_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != (PTR_W + 1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/sbfe_back.sv
// ----------------------------------------------------------------------------
// sbfe_back
// Walks the records of the queued frame and drives the registered record
// channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  sbfe_pkg::frame_t head,
	output logic             pop,
	sbfe_rec_if.source       recs
);
	import sbfe_pkg::*;

	logic               valid_q;
	logic [3:0]         idx_q;
	tag_t               tag;
	logic               is_last;
	logic               load;
	logic [VALUE_W-1:0] value;

	status_t            status_q;
	tag_t               tag_q;
	logic [VALUE_W-1:0] value_q;
	logic [PKT_W-1:0]   pkts_q;
	logic [BYTES_W-1:0] nbytes_q;
	logic               last_q;

	assign tag     = (head.status == ST_SHORT) ? TAG_NONE : tag_t'(idx_q);
	assign is_last = (head.status != ST_OK) || (idx_q == head.last_tag);
	assign load    = head_valid && (!valid_q || recs.ready);
	assign pop     = load && is_last;

	always_comb begin
		case (tag)
			TAG_PROTO:     value = (head.status == ST_PROTO) ?
				VALUE_W'({head.cap[0], head.cap[1]}) : '0;
			TAG_VERSION:   value = VALUE_W'(head.cap[2]);
			TAG_TYPE:      value = VALUE_W'(head.cap[3]);
			TAG_FLAGS:     value = VALUE_W'(head.cap[4]);
			TAG_ROOT:      value = {head.cap[5], head.cap[6], head.cap[7], head.cap[8],
				head.cap[9], head.cap[10], head.cap[11], head.cap[12]};
			TAG_COST:      value = VALUE_W'({head.cap[13], head.cap[14], head.cap[15],
				head.cap[16]});
			TAG_BRIDGE:    value = {head.cap[17], head.cap[18], head.cap[19], head.cap[20],
				head.cap[21], head.cap[22], head.cap[23], head.cap[24]};
			TAG_PORT:      value = VALUE_W'({head.cap[25], head.cap[26]});
			TAG_MSG_AGE:   value = VALUE_W'({head.cap[27], head.cap[28]});
			TAG_MAX_AGE:   value = VALUE_W'({head.cap[29], head.cap[30]});
			TAG_HELLO:     value = VALUE_W'({head.cap[31], head.cap[32]});
			TAG_FWD_DELAY: value = VALUE_W'({head.cap[33], head.cap[34]});
			TAG_V1LEN:     value = VALUE_W'(head.cap[35]);
			default:       value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (recs.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= head.status;
			tag_q    <= tag;
			value_q  <= value;
			pkts_q   <= head.pkts;
			nbytes_q <= head.nbytes;
			last_q   <= is_last;
		end
	end

	assign recs.valid        = valid_q;
	assign recs.status       = status_q;
	assign recs.field_tag    = tag_q;
	assign recs.field_value  = value_q;
	assign recs.packet_count = pkts_q;
	assign recs.byte_count   = nbytes_q;
	assign recs.last_record  = last_q;

endmodule

FILE: hw/rtl/stp_bpdu_field_extractor.sv
// ----------------------------------------------------------------------------
// stp_bpdu_field_extractor
// Spanning tree BPDU field extractor: byte stream in, tagged field records out.
//
// channel  modport  payload                                        transfer
// data     sink     data_byte[8] last_byte                         valid & ready
// records  source   status[2] field_tag[4] field_value[64]         valid & ready
//                   packet_count[32] byte_count[48] last_record
//
// One byte is taken per cycle; a frame's records leave one per cycle while the
// output is taken, 1 to 13 per frame, via the frame queue and output register.
// Byte intake stalls only while the two-entry frame queue is full.
// The record output is registered; a stalled record holds until taken.
// Reset clears position, counters, queue and output valid; capture is unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_bpdu_field_extractor #(
	parameter int LEN_BITS = sbfe_pkg::LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sbfe_byte_if.sink   data,
	sbfe_rec_if.source  records
);
	import sbfe_pkg::*;

	logic   push_valid;
	logic   push_ready;
	frame_t push_data;
	logic   head_valid;
	logic   pop;
	frame_t head;

	sbfe_front #(
		.LEN_BITS (LEN_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sbfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_data   (head)
	);

	sbfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.recs       (records)
	);

endmodule

FILE: hw/rtl/sbfe_checker.sv
// ----------------------------------------------------------------------------
// sbfe_checker
// Port-level checks on the record channel of the BPDU field extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stp_bpdu_field_extractor_macros.svh"

module sbfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  status,
	input logic [3:0]  field_tag,
	input logic [63:0] field_value,
	input logic        last_record
);
	import sbfe_pkg::*;

	`SBFE_ASSERT_IMPL(a_err_single, valid && (status != ST_OK), last_record)
	`SBFE_ASSERT_IMPL(a_short_rec, valid && (status == ST_SHORT),
		(field_tag == TAG_NONE) && (field_value == 64'h0))
	`SBFE_ASSERT_IMPL(a_ok_proto_zero, valid && (status == ST_OK) && (field_tag == TAG_PROTO),
		(field_value == 64'h0) && !last_record)
	`SBFE_ASSERT_HOLD(a_rec_hold, valid && !ready, {valid, status, field_tag, field_value})

endmodule

bind stp_bpdu_field_extractor sbfe_checker u_sbfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (records.valid),
	.ready       (records.ready),
	.status      (records.status),
	.field_tag   (records.field_tag),
	.field_value (records.field_value),
	.last_record (records.last_record)
);
